>>> src/bavg_pkg.sv
// Shared types and constants of the block average downscaler
`timescale 1ns / 1ps

package bavg_pkg;

    // field widths
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 10;
    localparam int ROW_W      = 10;
    localparam int HGT_W      = 11;
    localparam int RS_W       = 12;
    localparam int SUM_W      = 16;
    localparam int BS_REG_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // tallest frame the row counter covers
    localparam int HEIGHT_LIMIT = 1024;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    // register reset values
    localparam logic [BS_REG_W-1:0] BLOCK_SIZE_RESET   = 5'd2;
    localparam logic [HGT_W-1:0]    IMAGE_WIDTH_RESET  = 11'd512;
    localparam logic [HGT_W-1:0]    IMAGE_HEIGHT_RESET = 11'd512;

    // divider operand selection
    localparam logic [1:0] DIV_AVG = 2'd0;
    localparam logic [1:0] DIV_COL = 2'd1;
    localparam logic [1:0] DIV_ROW = 2'd2;

    // input beat
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_pix_beat;

    // output beat
    typedef struct packed {
        logic [PIX_W-1:0]   average;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic               frame_done;
    } t_avg_beat;

    // controller to datapath
    typedef struct packed {
        logic       accept;
        logic       pos_step;
        logic       eval;
        logic       sum;
        logic       div_start;
        logic [1:0] div_sel;
        logic       rs_col_load;
        logic       rs_row_load;
        logic       out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic bs_write;
        logic eval_sum;
        logic pend_out;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

>>> src/bavg_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module bavg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/bavg_divider.sv
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module bavg_divider #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quotient,
    output logic [DEN_W-1:0] o_remainder
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_count;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   w_shift;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;
    logic [DEN_W-1:0] n_rem;

    // one trial subtraction
    always_comb begin
        w_shift = {r_rem, r_quo[NUM_W-1]};
        w_diff  = w_shift - {1'b0, r_den};
        w_ge    = (w_shift >= {1'b0, r_den});
        n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
            r_count <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_count <= r_count - CNT_W'(1);
            if (r_count == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // quotient and remainder shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

`ifndef SYNTHESIS
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (!r_busy && $past(r_busy)))
        else $error("divider done without a finished run");
`endif

endmodule

>>> src/bavg_datapath.sv
// Datapath: registers, position counters, column sums, divider and output beat
`timescale 1ns / 1ps

module bavg_datapath
    import bavg_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_BLOCK = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_pix_beat             i_in_beat,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic                  o_out_valid,
    output t_avg_beat             o_out_beat,
    input  logic                  i_out_stall
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int BSW = $clog2(MAX_BLOCK + 1);
    localparam int DVW = 2 * BSW;
    localparam int XW  = ((WW > BSW) ? WW : BSW) + 2;
    localparam int YW  = ((HGT_W > BSW) ? HGT_W : BSW) + 2;

    // configuration registers
    logic [BS_REG_W-1:0] r_block_size;
    logic [HGT_W-1:0]    r_image_width;
    logic [HGT_W-1:0]    r_image_height;

    // effective settings
    logic [BSW-1:0]   w_bs;
    logic [WW-1:0]    w_wid;
    logic [HGT_W-1:0] w_hgt;
    logic [DVW-1:0]   w_bs_sq;

    // latched input beat
    logic [PIX_W-1:0] r_pix;
    logic             r_start;

    // position counters
    logic [CW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [BSW-1:0]   r_cib, n_cib;
    logic [BSW-1:0]   r_rib, n_rib;
    logic [CW-1:0]    r_bx,  n_bx;
    logic [ROW_W-1:0] r_by,  n_by;

    // advance logic
    logic [WW-1:0]    w_col_base;
    logic             w_col_wrap;
    logic [ROW_W:0]   w_row_base;
    logic             w_row_wrap;
    logic [BSW-1:0]   w_cib_p1;
    logic [BSW-1:0]   w_rib_p1;

    // block evaluation
    logic [XW-1:0]    w_xs;
    logic [YW-1:0]    w_ys;
    logic             w_in_block;
    logic             w_last;
    logic             w_col_end;
    logic             w_row_end;
    logic [RS_W-1:0]  w_rs_add;

    // running sums and latched block state
    logic [RS_W-1:0]  r_rs;
    logic             r_row0;
    logic             r_pend_out;
    logic             r_last;
    logic [CW-1:0]    r_blk_x;
    logic [ROW_W-1:0] r_blk_y;
    logic [SUM_W-1:0] w_ram_rd;
    logic [SUM_W-1:0] w_total;

    // divider hookup
    logic [SUM_W-1:0] w_div_num;
    logic [DVW-1:0]   w_div_den;
    logic             w_div_busy;
    logic             w_div_done;
    logic [SUM_W-1:0] w_div_quo;
    logic [DVW-1:0]   w_div_rem;

    // output register
    logic             r_out_valid;
    t_avg_beat        r_out_beat;
    logic [PIX_W-1:0] w_avg;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size   <= BLOCK_SIZE_RESET;
            r_image_width  <= IMAGE_WIDTH_RESET;
            r_image_height <= IMAGE_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BLOCK_SIZE:   r_block_size   <= i_cfg_data[BS_REG_W-1:0];
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp settings into range
    always_comb begin
        if (r_block_size == '0) begin
            w_bs = BSW'(1);
        end else if (int'(r_block_size) > MAX_BLOCK) begin
            w_bs = BSW'(MAX_BLOCK);
        end else begin
            w_bs = BSW'(r_block_size);
        end
        if (r_image_width == '0) begin
            w_wid = WW'(1);
        end else if (int'(r_image_width) > MAX_WIDTH) begin
            w_wid = WW'(MAX_WIDTH);
        end else begin
            w_wid = WW'(r_image_width);
        end
        if (r_image_height == '0) begin
            w_hgt = HGT_W'(1);
        end else if (int'(r_image_height) > HEIGHT_LIMIT) begin
            w_hgt = HGT_W'(HEIGHT_LIMIT);
        end else begin
            w_hgt = r_image_height;
        end
        w_bs_sq = DVW'(w_bs) * DVW'(w_bs);
    end

    // latch the accepted beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix   <= i_in_beat.pixel;
            r_start <= i_in_beat.frame_start;
        end
    end

    // wrap checks: pos_step checks the stored column, eval steps one column on
    always_comb begin
        w_cib_p1   = r_cib + BSW'(1);
        w_rib_p1   = r_rib + BSW'(1);
        w_col_base = i_cmd.eval ? (WW'(r_col) + WW'(1)) : WW'(r_col);
        w_col_wrap = (w_col_base >= w_wid);
        w_row_base = w_col_wrap ? ({1'b0, r_row} + (ROW_W + 1)'(1)) : {1'b0, r_row};
        w_row_wrap = (w_row_base >= w_hgt);
    end

    // next position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_cib = r_cib;
        n_rib = r_rib;
        n_bx  = r_bx;
        n_by  = r_by;
        if (i_cmd.pos_step && r_start) begin
            n_col = '0;
            n_row = '0;
            n_cib = '0;
            n_rib = '0;
            n_bx  = '0;
            n_by  = '0;
        end else if (i_cmd.pos_step || i_cmd.eval) begin
            if (w_col_wrap) begin
                n_col = '0;
                n_cib = '0;
                n_bx  = '0;
            end else begin
                n_col = w_col_base[CW-1:0];
                if (i_cmd.eval) begin
                    if (w_cib_p1 == w_bs) begin
                        n_cib = '0;
                        n_bx  = r_bx + CW'(1);
                    end else begin
                        n_cib = w_cib_p1;
                    end
                end
            end
            if (w_row_wrap) begin
                n_row = '0;
                n_rib = '0;
                n_by  = '0;
            end else if (w_col_wrap) begin
                n_row = w_row_base[ROW_W-1:0];
                if (w_rib_p1 == w_bs) begin
                    n_rib = '0;
                    n_by  = r_by + ROW_W'(1);
                end else begin
                    n_rib = w_rib_p1;
                end
            end
        end else if (i_cmd.rs_col_load) begin
            n_cib = BSW'(w_div_rem);
            n_bx  = CW'(w_div_quo);
        end else if (i_cmd.rs_row_load) begin
            n_rib = BSW'(w_div_rem);
            n_by  = ROW_W'(w_div_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_cib <= '0;
            r_rib <= '0;
            r_bx  <= '0;
            r_by  <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_cib <= n_cib;
            r_rib <= n_rib;
            r_bx  <= n_bx;
            r_by  <= n_by;
        end
    end

    // block membership, taken from the block start column and row
    always_comb begin
        w_xs       = XW'(r_col) - XW'(r_cib);
        w_ys       = YW'(r_row) - YW'(r_rib);
        w_in_block = ((w_xs + XW'(w_bs)) <= XW'(w_wid)) &&
                     ((w_ys + YW'(w_bs)) <= YW'(w_hgt));
        w_last     = ((w_xs + XW'({w_bs, 1'b0})) > XW'(w_wid)) &&
                     ((w_ys + YW'({w_bs, 1'b0})) > YW'(w_hgt));
        w_col_end  = (w_cib_p1 == w_bs);
        w_row_end  = (w_rib_p1 == w_bs);
        w_rs_add   = r_rs + RS_W'(r_pix);
    end

    // running row sum, cleared by frame start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs       <= '0;
            r_pend_out <= 1'b0;
        end else if (i_cmd.pos_step && r_start) begin
            r_rs <= '0;
        end else if (i_cmd.eval) begin
            r_pend_out <= w_in_block && w_col_end && w_row_end;
            if (w_in_block) begin
                r_rs <= (r_cib == '0) ? RS_W'(r_pix) : w_rs_add;
            end
        end
    end

    // block coordinates for the sum and the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_row0  <= (r_rib == '0);
            r_last  <= w_last;
            r_blk_x <= r_bx;
            r_blk_y <= r_by;
        end
    end

    // column sums of the current block row
    bavg_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_col_sums (
        .i_clk   (i_clk),
        .i_we    (i_cmd.sum),
        .i_waddr (r_blk_x),
        .i_wdata (w_total),
        .i_re    (i_cmd.eval),
        .i_raddr (r_bx),
        .o_rdata (w_ram_rd)
    );

    assign w_total = r_row0 ? SUM_W'(r_rs) : (w_ram_rd + SUM_W'(r_rs));

    // divider operands
    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_AVG: begin
                w_div_num = w_total;
                w_div_den = w_bs_sq;
            end
            DIV_COL: begin
                w_div_num = SUM_W'(r_col);
                w_div_den = DVW'(w_bs);
            end
            DIV_ROW: begin
                w_div_num = SUM_W'(r_row);
                w_div_den = DVW'(w_bs);
            end
            default: begin
                w_div_num = '0;
                w_div_den = DVW'(w_bs);
            end
        endcase
    end

    bavg_divider #(
        .NUM_W (SUM_W),
        .DEN_W (DVW)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_num       (w_div_num),
        .i_den       (w_div_den),
        .o_busy      (w_div_busy),
        .o_done      (w_div_done),
        .o_quotient  (w_div_quo),
        .o_remainder (w_div_rem)
    );

    // saturate the mean to pixel range
    assign w_avg = (|w_div_quo[SUM_W-1:PIX_W]) ? {PIX_W{1'b1}} : w_div_quo[PIX_W-1:0];

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_beat.average    <= w_avg;
            r_out_beat.out_x      <= COORD_W'(r_blk_x);
            r_out_beat.out_y      <= r_blk_y;
            r_out_beat.frame_done <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // status back to the controller
    always_comb begin
        o_stat.bs_write = i_cfg_we && (i_cfg_index == REG_BLOCK_SIZE);
        o_stat.eval_sum = w_in_block && w_col_end;
        o_stat.pend_out = r_pend_out;
        o_stat.div_busy = w_div_busy;
        o_stat.div_done = w_div_done;
        o_stat.out_free = !r_out_valid || !i_out_stall;
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_out_valid && i_out_stall))
        else $error("result loaded over a stalled beat");
`endif

endmodule

>>> src/bavg_controller.sv
// Controller: sequences accept, position update, sum, divide and output load
`timescale 1ns / 1ps

module bavg_controller
    import bavg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE        = 4'd0;
    localparam logic [3:0] S_POS         = 4'd1;
    localparam logic [3:0] S_EVAL        = 4'd2;
    localparam logic [3:0] S_SUM         = 4'd3;
    localparam logic [3:0] S_DIV         = 4'd4;
    localparam logic [3:0] S_EMIT        = 4'd5;
    localparam logic [3:0] S_RS_COL      = 4'd6;
    localparam logic [3:0] S_RS_COL_WAIT = 4'd7;
    localparam logic [3:0] S_RS_ROW      = 4'd8;
    localparam logic [3:0] S_RS_ROW_WAIT = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_resync, n_resync;

    // input beat taken only when idle with in-block positions in step
    assign o_in_stall = !((r_state == S_IDLE) && !r_resync && !i_stat.bs_write);

    always_comb begin
        n_state  = r_state;
        n_resync = r_resync;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (r_resync) begin
                    n_resync = 1'b0;
                    n_state  = S_RS_COL;
                end else if (i_in_valid && !o_in_stall) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_POS;
                end
            end
            S_POS: begin
                o_cmd.pos_step = 1'b1;
                n_state        = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_stat.eval_sum ? S_SUM : S_IDLE;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                if (i_stat.pend_out) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_AVG;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_RS_COL: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_COL;
                n_state         = S_RS_COL_WAIT;
            end
            S_RS_COL_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.rs_col_load = 1'b1;
                    n_state           = S_RS_ROW;
                end
            end
            S_RS_ROW: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_ROW;
                n_state         = S_RS_ROW_WAIT;
            end
            S_RS_ROW_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.rs_row_load = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // a new block size always forces a fresh resync
        if (i_stat.bs_write) begin
            n_resync = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_resync <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_resync <= n_resync;
        end
    end

`ifndef SYNTHESIS
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_stat.div_busy)
        else $error("divider started while busy");
    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> i_stat.div_busy)
        else $error("divider did not take its start");
`endif

endmodule

>>> src/block_average_downscaler_unit.sv
// Top level of the block average downscaler
//
//   channel  | direction | handshake              | beat
//   ---------+-----------+------------------------+------------------------------
//   in       | in        | i_in_valid / o_in_stall | pixel, frame_start
//   out      | out       | o_out_valid / i_out_stall | average, out_x, out_y, frame_done
//   cfg      | in        | i_cfg_we               | index 0..2, data 11 bits
//
// A pixel passes accept, position update and block evaluation; one that closes a
// block row segment adds a column sum read, add and write, and one that closes a
// block waits for its mean from a 16-step shift-subtract divider and a free output.
// A block size write resynchronizes the in-block counters through two passes of
// the same divider, with the input stalled meanwhile.
// Reset is synchronous; the column sum memory needs no clearing pass.
// One result waits in the output register while the next pixels keep flowing.
`timescale 1ns / 1ps

module block_average_downscaler_unit
    import bavg_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_BLOCK = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_pix_beat             i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_avg_beat             o_out_beat,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    bavg_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    bavg_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_beat   (i_in_beat),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .i_out_stall (i_out_stall)
    );

endmodule

>>> verif/tb_block_average_downscaler_unit.sv
// Self-checking testbench for the block average downscaler: predicted block means vs. output beats
`timescale 1ns / 1ps

module tb_block_average_downscaler_unit;
    import bavg_pkg::*;

    localparam int MAX_WIDTH       = 1024;
    localparam int MAX_BLOCK       = 16;
    localparam int SETTLE_CYCLES   = 48;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PIXEL_TARGET    = 1750;
    localparam int REPORT_LIMIT    = 10;

    // index with no register behind it, writes to it must do nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum {PIX_RANDOM, PIX_WHITE, PIX_BLACK, PIX_EXTREME} t_pix_mode;
    typedef enum {SEQ_FRAMES, SEQ_RESUME, SEQ_NOISE} t_seq_kind;
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    // predicts block means and holds them until the matching output beat arrives
    class downscale_scoreboard;
        int unsigned      bs_reg, width_reg, height_reg;
        logic [SUM_W-1:0] col_sums [MAX_WIDTH];
        bit               sum_written [MAX_WIDTH];
        int unsigned      pix_col, pix_row, row_sum;
        t_avg_beat        pending [$];
        int               errors;

        function new();
            bs_reg     = BLOCK_SIZE_RESET;
            width_reg  = IMAGE_WIDTH_RESET;
            height_reg = IMAGE_HEIGHT_RESET;
            pix_col    = 0;
            pix_row    = 0;
            row_sum    = 0;
            errors     = 0;
            foreach (sum_written[i]) sum_written[i] = 1'b0;
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_BLOCK_SIZE:   bs_reg = data[BS_REG_W-1:0];
                REG_IMAGE_WIDTH:  width_reg = data;
                REG_IMAGE_HEIGHT: height_reg = data;
                default: ;
            endcase
        endfunction

        // one pixel through the downscaler, state is only updated when commit is set
        function bit advance(t_pix_beat b, bit commit, output t_avg_beat res, output bit stale);
            int unsigned bs, w, h, col, row, rs, bx, by, idx, total, avg;
            bit          hit;
            bs    = clamp(bs_reg, MAX_BLOCK);
            w     = clamp(width_reg, MAX_WIDTH);
            h     = clamp(height_reg, HEIGHT_LIMIT);
            hit   = 1'b0;
            stale = 1'b0;
            res   = '0;
            col   = pix_col;
            row   = pix_row;
            rs    = row_sum;
            if (b.frame_start) begin
                col = 0;
                row = 0;
                rs  = 0;
            end
            // counters past a shrunken frame wrap first
            if (col >= w) begin
                col = 0;
                row++;
            end
            if (row >= h) row = 0;
            bx = col / bs;
            by = row / bs;
            // pixels of partial edge blocks are dropped
            if (bx < w / bs && by < h / bs) begin
                rs = (col % bs == 0) ? b.pixel : ((rs + b.pixel) & 32'hFFF);
                if (col % bs == bs - 1) begin
                    idx = bx % MAX_WIDTH;
                    if (row % bs == 0) begin
                        total = rs;
                    end else begin
                        stale = !sum_written[idx];
                        total = (col_sums[idx] + rs) & 32'hFFFF;
                    end
                    if (commit) begin
                        col_sums[idx]    = SUM_W'(total);
                        sum_written[idx] = 1'b1;
                    end
                    if (row % bs == bs - 1) begin
                        avg = total / (bs * bs);
                        // mixed block sizes can overshoot a full-scale mean
                        if (avg > 255) avg = 255;
                        res.average    = PIX_W'(avg);
                        res.out_x      = COORD_W'(bx);
                        res.out_y      = COORD_W'(by);
                        res.frame_done = (bx == w / bs - 1) && (by == h / bs - 1);
                        hit            = 1'b1;
                    end
                end
            end
            col++;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) row = 0;
            end
            if (commit) begin
                pix_col = col;
                pix_row = row;
                row_sum = rs;
            end
            return hit;
        endfunction

        // true when this pixel would fold in a column sum never written since reset
        function bit reads_stale(t_pix_beat b);
            t_avg_beat r;
            bit        s;
            void'(advance(b, 1'b0, r, s));
            return s;
        endfunction

        function void note_pixel(t_pix_beat b);
            t_avg_beat r;
            bit        s;
            if (advance(b, 1'b1, r, s)) pending.push_back(r);
        endfunction

        function void check_average(t_avg_beat got);
            t_avg_beat want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected beat: avg %0d x %0d y %0d done %0b",
                             got.average, got.out_x, got.out_y, got.frame_done);
                return;
            end
            want = pending.pop_front();
            if (got.average !== want.average || got.out_x !== want.out_x ||
                got.out_y !== want.out_y || got.frame_done !== want.frame_done) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display({"mismatch: expected avg %0d x %0d y %0d done %0b, ",
                              "got avg %0d x %0d y %0d done %0b"},
                             want.average, want.out_x, want.out_y, want.frame_done,
                             got.average, got.out_x, got.out_y, got.frame_done);
            end
        endfunction
    endclass

    bit                    i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_pix_beat             i_in_beat;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_avg_beat             o_out_beat;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    downscale_scoreboard sb;
    int                  pixels_sent;
    int                  burst_left;
    bit                  gapless;
    bit                  hold_off_req;

    block_average_downscaler_unit #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // check every accepted output beat
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            sb.check_average(o_out_beat);
    end

    // register write, only while the block is quiet
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic set_regs(logic [CFG_DATA_W-1:0] bs_data, logic [CFG_DATA_W-1:0] w_data,
                            logic [CFG_DATA_W-1:0] h_data, bit all);
        if (all || $urandom_range(0, 2) != 0) write_cfg(REG_BLOCK_SIZE, bs_data);
        if (all || $urandom_range(0, 2) != 0) write_cfg(REG_IMAGE_WIDTH, w_data);
        if (all || $urandom_range(0, 2) != 0) write_cfg(REG_IMAGE_HEIGHT, h_data);
        if ($urandom_range(0, 7) == 0) write_cfg(REG_SPARE, CFG_DATA_W'($urandom));
    endtask

    // stop offering and wait for every predicted mean
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // offer one pixel beat in the current burst and wait for it to be taken
    task automatic push_pixel(logic [PIX_W-1:0] pix, bit start);
        t_pix_beat b;
        int        gap;
        b.pixel       = pix;
        b.frame_start = start;
        // restart the frame rather than fold in a column sum never written
        if (!start && sb.reads_stale(b)) b.frame_start = 1'b1;
        if (!gapless && burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        i_in_beat  <= b;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_pixel(b);
        pixels_sent++;
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(t_pix_mode m);
        case (m)
            PIX_WHITE:   return '1;
            PIX_BLACK:   return '0;
            PIX_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
            default:     return ($urandom_range(0, 7) == 0) ?
                                ($urandom_range(0, 1) ? '1 : '0) : PIX_W'($urandom);
        endcase
    endfunction

    // output stall pattern, with one long hold-off on request
    initial begin
        int          seg_left;
        int          period;
        int          cyc;
        bit          s;
        t_stall_mode mode;
        seg_left    = 0;
        period      = 2;
        cyc         = 0;
        mode        = STALL_NONE;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    mode     = t_stall_mode'($urandom_range(0, 3));
                    seg_left = $urandom_range(20, 200);
                    period   = $urandom_range(2, 7);
                end
                seg_left--;
                cyc++;
                case (mode)
                    STALL_NONE:  s = 1'b0;
                    STALL_LIGHT: s = ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: s = ($urandom_range(0, 3) != 0);
                    default:     s = (cyc % period == 0);
                endcase
                i_out_stall <= s;
            end
        end
    end

    // run limit
    initial begin
        #2_000_000;
        $display("tb_block_average_downscaler_unit: done, errors");
        $finish;
    end

    // stimulus
    initial begin
        logic [PIX_W-1:0] two_by_two [9];
        logic [PIX_W-1:0] single_px [4];
        int               r, bs, bs_e, w, h, w_e, h_e, frame_px, count, cap;
        t_seq_kind        kind;
        t_pix_mode        pmode;
        bit               start;

        two_by_two   = '{255, 255, 0, 1, 255, 255, 0, 0, 200};
        single_px    = '{0, 255, 128, 77};
        sb           = new();
        pixels_sent  = 0;
        burst_left   = 0;
        gapless      = 1'b0;
        hold_off_req = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_beat    = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = REG_BLOCK_SIZE;
        i_cfg_data   = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 2x2 blocks on a 4x2 image: full-scale and near-zero means, then a wrap
        set_regs(11'd2, 11'd4, 11'd2, 1'b1);
        foreach (two_by_two[i]) push_pixel(two_by_two[i], i == 0);

        // unit blocks with junk above the block size field, one row frame
        drain();
        set_regs(11'h7E1, 11'd3, 11'd1, 1'b1);
        foreach (single_px[i]) push_pixel(single_px[i], i == 0);

        // oversize block size clamps to 16, larger than an 8x1 image: no means
        drain();
        set_regs(11'h01F, 11'd8, 11'd0, 1'b1);
        for (int i = 0; i < 4; i++) push_pixel(PIX_W'($urandom), i == 0);

        // zero block size acts as one, oversize width clamps
        drain();
        set_regs(11'd0, 11'h7FF, 11'd1, 1'b1);
        for (int i = 0; i < 3; i++) push_pixel(PIX_W'($urandom), i == 0);

        // long output hold-off while input keeps coming, block backs up
        drain();
        set_regs(11'd1, 11'd16, 11'd4, 1'b1);
        gapless      = 1'b1;
        hold_off_req = 1'b1;
        for (int i = 0; i < 64; i++) push_pixel(PIX_W'($urandom), i == 0);
        gapless = 1'b0;

        // random phases
        while (pixels_sent < PIXEL_TARGET) begin
            drain();
            r = $urandom_range(0, 19);
            if (r < 12)       bs = $urandom_range(1, 4);
            else if (r < 16)  bs = $urandom_range(5, 16);
            else if (r == 16) bs = 0;
            else if (r == 17) bs = $urandom_range(17, 31);
            else if (r == 18) bs = 16;
            else              bs = 1;
            bs_e = sb.clamp(bs, MAX_BLOCK);

            r = $urandom_range(0, 19);
            if (r < 14)       w = (bs_e > 4) ?
                                  bs_e * $urandom_range(1, 2) + $urandom_range(0, 3) :
                                  bs_e * $urandom_range(1, 6) + $urandom_range(0, bs_e - 1);
            else if (r == 14) w = 0;
            else if (r == 15) w = 1;
            else if (r == 16) w = 1024;
            else if (r == 17) w = $urandom_range(1025, 2047);
            else if (r == 18) w = $urandom_range(1, 1024);
            else              w = (bs_e > 1) ? bs_e - 1 : 1;

            r = $urandom_range(0, 19);
            if (r < 15)       h = (bs_e > 4) ? bs_e :
                                  bs_e * $urandom_range(1, 4) + $urandom_range(0, bs_e - 1);
            else if (r == 15) h = 0;
            else if (r == 16) h = 1;
            else if (r == 17) h = 1024;
            else if (r == 18) h = $urandom_range(1025, 2047);
            else              h = $urandom_range(1, 1024);

            set_regs({6'($urandom), 5'(bs)}, CFG_DATA_W'(w), CFG_DATA_W'(h), 1'b0);
            w_e      = sb.clamp(sb.width_reg, MAX_WIDTH);
            h_e      = sb.clamp(sb.height_reg, HEIGHT_LIMIT);
            frame_px = w_e * h_e;

            r = $urandom_range(0, 19);
            kind    = (r < 15) ? SEQ_FRAMES : (r < 18) ? SEQ_RESUME : SEQ_NOISE;
            r = $urandom_range(0, 9);
            pmode   = (r < 3) ? t_pix_mode'(r + 1) : PIX_RANDOM;
            gapless = ($urandom_range(0, 4) == 0);

            count = frame_px * $urandom_range(1, 2);
            cap   = $urandom_range(60, 300);
            if (count > cap) count = (frame_px <= 600) ? frame_px : cap;
            if (kind == SEQ_NOISE) count = $urandom_range(20, 120);

            for (int i = 0; i < count; i++) begin
                case (kind)
                    SEQ_FRAMES: start = (i % frame_px == 0) &&
                                        (i == 0 || $urandom_range(0, 3) != 0);
                    SEQ_RESUME: start = ($urandom_range(0, 63) == 0);
                    default:    start = ($urandom_range(0, 5) == 0);
                endcase
                push_pixel(pick_pixel(pmode), start);
            end
        end
        gapless = 1'b0;

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending.size() != 0)
            $display("%0d predicted means never arrived", sb.pending.size());
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_block_average_downscaler_unit: done, clean");
        end else begin
            $display("tb_block_average_downscaler_unit: done, errors");
        end
        $finish;
    end

endmodule
